### rtl/core/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared codes and types for the stable min-first priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // Command codes on func
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Status returned with every result
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } smpq_err_t;

  // Row-wide move issued to every cell in the same cycle
  typedef struct packed {
    logic ins;  // insert new entry at its sorted place
    logic fwd;  // drop cell 0, every cell takes its right neighbor
  } smpq_ctrl_t;

endpackage

### rtl/core/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: holds an entry and swaps with its neighbors.
// ----------------------------------------------------------------------------
module smpq_cell #(
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 16
) (
  input  logic                 clk,
  input  smpq_pkg::smpq_ctrl_t ctrl,
  input  logic                 valid,      // slot below occupancy
  input  logic [ELEM_BITS-1:0] new_data,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic                 left_le,    // all slots left of here stay put
  input  logic [ELEM_BITS-1:0] left_data,
  input  logic [PRIO_BITS-1:0] left_prio,
  input  logic [ELEM_BITS-1:0] right_data,
  input  logic [PRIO_BITS-1:0] right_prio,
  output logic                 le,         // this slot stays put on insert
  output logic [ELEM_BITS-1:0] data,
  output logic [PRIO_BITS-1:0] prio
);

  logic [ELEM_BITS-1:0] data_next;
  logic [PRIO_BITS-1:0] prio_next;

  // Equal priorities stay ahead of the newcomer.
  assign le = valid && (prio <= new_prio);

  always_comb begin
    data_next = data;
    prio_next = prio;
    if (ctrl.ins && !le) begin
      if (left_le) begin
        data_next = new_data;
        prio_next = new_prio;
      end else begin
        data_next = left_data;
        prio_next = left_prio;
      end
    end else if (ctrl.fwd) begin
      data_next = right_data;
      prio_next = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule

### rtl/core/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded min-first priority queue held as a sorted row of shift cells.
// ----------------------------------------------------------------------------
// Timing: a command's result shows on done in the cycle after its transfer.
// Throughput: one command per cycle; busy stays low, since every cell settles
//   its new contents in the cycle of the transfer.
// Reset: rst clears the occupancy and the done strobe; cell contents are left
//   as they are and only cells below the occupancy are ever looked at.
// The receiver cannot stall: each result stands for exactly one cycle.
// ----------------------------------------------------------------------------
module stable_min_priority_queue #(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32,
  parameter int PRIO_BITS = 16,
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [ELEM_BITS-1:0] elem,
  input  logic [PRIO_BITS-1:0] priority_req,
  // result side
  output logic                 done,
  output logic [ELEM_BITS-1:0] front_elem,
  output logic [PRIO_BITS-1:0] front_priority,
  output logic [CNT_BITS-1:0]  count,
  output logic                 empty_res,
  output logic [1:0]           error
);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [CNT_BITS-1:0]   occ;
  logic [CNT_BITS-1:0]   occ_next;
  smpq_pkg::smpq_err_t   err;
  smpq_pkg::smpq_err_t   err_next;

  logic                  accept;
  logic                  is_full;
  logic                  is_empty;
  smpq_pkg::smpq_ctrl_t  ctrl;

  // Every command finishes in its own transfer cycle, so the row never blocks.
  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (occ == CNT_BITS'(DEPTH));
  assign is_empty = (occ == '0);

  // Full enqueue and empty dequeue leave the row untouched.
  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.fwd = 1'b0;
    occ_next = occ;
    err_next = smpq_pkg::ERR_OK;
    if (accept) begin
      if (func == smpq_pkg::FUNC_ENQ) begin
        if (is_full) begin
          err_next = smpq_pkg::ERR_FULL;
        end else begin
          ctrl.ins = 1'b1;
          occ_next = occ + 1'b1;
        end
      end else begin
        if (is_empty) begin
          err_next = smpq_pkg::ERR_EMPTY;
        end else begin
          ctrl.fwd = 1'b1;
          occ_next = occ - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      done <= 1'b0;
    end else begin
      occ  <= occ_next;
      done <= accept;
    end
    err <= err_next;
  end

  // --------------------------------------------------------------------------
  // Cell row: cell 0 is the front, entries ascend in priority to the right.
  // le[i] marks cells that keep their entry on insert; it is a prefix of the
  // row because the row is sorted, so the first cell without it takes the
  // new entry and everything behind it moves one place right.
  // --------------------------------------------------------------------------
  logic [ELEM_BITS-1:0] cell_data [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]     le;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_le;
    logic [ELEM_BITS-1:0] left_data;
    logic [PRIO_BITS-1:0] left_prio;
    logic [ELEM_BITS-1:0] right_data;
    logic [PRIO_BITS-1:0] right_prio;

    if (i == 0) begin : g_head
      // Nothing ahead of the front: it takes the new entry unless it stays.
      assign left_le   = 1'b1;
      assign left_data = cell_data[i];
      assign left_prio = cell_prio[i];
    end else begin : g_body
      assign left_le   = le[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    smpq_cell #(
      .ELEM_BITS(ELEM_BITS),
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (CNT_BITS'(i) < occ),
      .new_data   (elem),
      .new_prio   (priority_req),
      .left_le    (left_le),
      .left_data  (left_data),
      .left_prio  (left_prio),
      .right_data (right_data),
      .right_prio (right_prio),
      .le         (le[i]),
      .data       (cell_data[i]),
      .prio       (cell_prio[i])
    );
  end

  // --------------------------------------------------------------------------
  // Result: queue state right after the last transfer.
  // --------------------------------------------------------------------------
  assign front_elem     = is_empty ? '0 : cell_data[0];
  assign front_priority = is_empty ? '0 : cell_prio[0];
  assign count          = occ;
  assign empty_res      = is_empty;
  assign error          = err;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_done_follows_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("no result after a transfer");

  a_no_spurious_done : assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without a transfer");

  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_BITS'(DEPTH))
    else $error("occupancy beyond depth");

  a_full_drop : assert property (@(posedge clk) disable iff (rst)
    (accept && func == smpq_pkg::FUNC_ENQ && is_full)
      |=> (err == smpq_pkg::ERR_FULL) && (occ == CNT_BITS'(DEPTH)))
    else $error("enqueue on full queue not dropped");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> (occ == $past(occ) + 1'b1) && !is_empty)
    else $error("insert did not grow the queue");

endmodule
